@@ rtl/b64sd_pkg.sv @@
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types and constants shared by the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

    localparam int CAP_W  = 24;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;

    localparam logic [CAP_W-1:0]  CAP_MAX    = 24'hFF_FFFF;
    localparam logic [CAP_W-1:0]  CAP_RESET  = 24'hFF_FFFF;

    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_text;
    } char_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data_byte;
        logic [CAP_W-1:0]  byte_count;
        logic              last;
    } res_item_t;

    // Returns {hit, value}. Both the standard and the URL-safe alphabet map.
    function automatic logic [6:0] six_bits(input logic [CHAR_W-1:0] ch);
        logic [6:0] r;
        r = 7'd0;
        if (ch >= "A" && ch <= "Z")
        begin
            r = {1'b1, 6'(ch - 8'd65)};
        end
        else if (ch >= "a" && ch <= "z")
        begin
            r = {1'b1, 6'(ch - 8'd97 + 8'd26)};
        end
        else if (ch >= "0" && ch <= "9")
        begin
            r = {1'b1, 6'(ch - 8'd48 + 8'd52)};
        end
        else if (ch == "+" || ch == "-")
        begin
            r = {1'b1, 6'd62};
        end
        else if (ch == "/" || ch == "_")
        begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

@@ rtl/base64_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 decoder: one character in, decoded bytes and a status out.
// ----------------------------------------------------------------------------
// Usage:
// Characters arrive on the char channel (valid/ready), one per transaction,
// with end_of_text set on the last character of a message. Both the standard
// and the URL-safe alphabets decode; padding, whitespace and other bytes are
// skipped but still counted as characters.
// Results leave on the res channel: a data transaction for each finished
// byte, and after the last character a status transaction (ok, too long or
// empty) that carries the byte count and has last set.
// The decode runs in the cycle of acceptance and its results are written to
// a four-entry result queue, so a result is registered before it is visible
// on the res channel. One character is taken every cycle while the queue has
// room; a character causes at most two results, and the queue must have two
// free entries for a character to be accepted, which is what sets the rate
// when the receiver is slower than one result per cycle.
// byte_cap may be written through cfg_we/cfg_wdata while no message is open.
// Reset empties the queue, clears the message state and sets byte_cap to its
// maximum. A stall on the res channel fills the queue and then holds off the
// char channel; nothing is lost.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     char_valid,
    output logic                     char_ready,
    input  b64sd_pkg::char_item_t    char_item,
    output logic                     res_valid,
    input  logic                     res_ready,
    output b64sd_pkg::res_item_t     res_item,
    input  logic                     cfg_we,
    input  logic [b64sd_pkg::CAP_W-1:0] cfg_wdata
);

    localparam int CAP_W = b64sd_pkg::CAP_W;
    localparam int CMP_W = (COUNT_WIDTH + 1 > CAP_W) ? COUNT_WIDTH + 1 : CAP_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [2:0] PEND_0 = 3'd0;
    localparam logic [2:0] PEND_2 = 3'd2;
    localparam logic [2:0] PEND_4 = 3'd4;
    localparam logic [2:0] PEND_6 = 3'd6;

    // Message state and configuration.
    logic [CAP_W-1:0]       byte_cap_reg;
    logic [5:0]             bit_store_reg,    bit_store_next;
    logic [2:0]             bits_pending_reg, bits_pending_next;
    logic [COUNT_WIDTH-1:0] chars_seen_reg,   chars_seen_next;
    logic [COUNT_WIDTH-1:0] bytes_made_reg,   bytes_made_next;

    // Result queue.
    b64sd_pkg::res_item_t   fifo_reg [4];
    logic [1:0]             wr_ptr_reg;
    logic [1:0]             rd_ptr_reg;
    logic [2:0]             count_reg;

    logic                   accept;
    logic                   pop;
    logic [6:0]             six;
    logic [11:0]            acc;
    logic                   byte_hit;
    logic [7:0]             byte_val;
    logic [COUNT_WIDTH-1:0] chars_inc;
    logic [CMP_W-1:0]       quarter;
    logic [CMP_W-1:0]       worst;
    logic [CMP_W-1:0]       bytes_ext;
    logic [CAP_W-1:0]       byte_count;
    logic [1:0]             end_kind;
    b64sd_pkg::res_item_t   data_res;
    b64sd_pkg::res_item_t   end_res;
    b64sd_pkg::res_item_t   res0;
    b64sd_pkg::res_item_t   res1;
    logic [1:0]             push_cnt;

    assign char_ready = (count_reg <= 3'd2);
    assign accept     = char_valid && char_ready;
    assign res_valid  = (count_reg != 3'd0);
    assign pop        = res_valid && res_ready;
    assign res_item   = fifo_reg[rd_ptr_reg];

    assign six = b64sd_pkg::six_bits(char_item.char_in);
    assign acc = {bit_store_reg, six[5:0]};

    // Only the pending bits are kept, so the new value and the stored bits
    // together hold pending+6 bits; a byte is due once that reaches eight.
    always_comb
    begin
        byte_hit          = 1'b0;
        byte_val          = 8'd0;
        bit_store_next    = bit_store_reg;
        bits_pending_next = bits_pending_reg;
        if (six[6])
        begin
            case (bits_pending_reg)
                PEND_2:
                begin
                    byte_hit          = 1'b1;
                    byte_val          = acc[7:0];
                    bit_store_next    = 6'd0;
                    bits_pending_next = PEND_0;
                end
                PEND_4:
                begin
                    byte_hit          = 1'b1;
                    byte_val          = acc[9:2];
                    bit_store_next    = {4'd0, acc[1:0]};
                    bits_pending_next = PEND_2;
                end
                PEND_6:
                begin
                    byte_hit          = 1'b1;
                    byte_val          = acc[11:4];
                    bit_store_next    = {2'd0, acc[3:0]};
                    bits_pending_next = PEND_4;
                end
                default:
                begin
                    bit_store_next    = six[5:0];
                    bits_pending_next = PEND_6;
                end
            endcase
        end
        if (char_item.end_of_text)
        begin
            bit_store_next    = 6'd0;
            bits_pending_next = PEND_0;
        end
    end

    always_comb
    begin
        chars_inc       = (chars_seen_reg == CNT_MAX) ? chars_seen_reg
                                                      : chars_seen_reg + 1'b1;
        bytes_made_next = bytes_made_reg;
        if (byte_hit && bytes_made_reg != CNT_MAX)
        begin
            bytes_made_next = bytes_made_reg + 1'b1;
        end

        quarter   = CMP_W'(chars_inc[COUNT_WIDTH-1:2]);
        worst     = (quarter << 1) + quarter + CMP_W'(3);
        bytes_ext = CMP_W'(bytes_made_next);

        if (bytes_ext > CMP_W'(b64sd_pkg::CAP_MAX))
        begin
            byte_count = b64sd_pkg::CAP_MAX;
        end
        else
        begin
            byte_count = bytes_ext[CAP_W-1:0];
        end

        if (worst > CMP_W'(byte_cap_reg))
        begin
            end_kind = b64sd_pkg::KIND_LONG;
        end
        else if (bytes_made_next == '0)
        begin
            end_kind = b64sd_pkg::KIND_EMPTY;
        end
        else
        begin
            end_kind = b64sd_pkg::KIND_OK;
        end

        data_res.kind       = b64sd_pkg::KIND_DATA;
        data_res.data_byte  = byte_val;
        data_res.byte_count = '0;
        data_res.last       = 1'b0;

        end_res.kind        = end_kind;
        end_res.data_byte   = 8'd0;
        end_res.byte_count  = byte_count;
        end_res.last        = 1'b1;

        res0     = byte_hit ? data_res : end_res;
        res1     = end_res;
        push_cnt = 2'(byte_hit) + 2'(char_item.end_of_text);

        chars_seen_next = chars_inc;
        if (char_item.end_of_text)
        begin
            chars_seen_next = '0;
            bytes_made_next = '0;
        end
        if (!accept)
        begin
            push_cnt = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cap_reg     <= b64sd_pkg::CAP_RESET;
            bit_store_reg    <= 6'd0;
            bits_pending_reg <= PEND_0;
            chars_seen_reg   <= '0;
            bytes_made_reg   <= '0;
            wr_ptr_reg       <= 2'd0;
            rd_ptr_reg       <= 2'd0;
            count_reg        <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                byte_cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                bit_store_reg    <= bit_store_next;
                bits_pending_reg <= bits_pending_next;
                chars_seen_reg   <= chars_seen_next;
                bytes_made_reg   <= bytes_made_next;
            end
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push_cnt) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

endmodule
